// ----- hdl/dht_pkg.sv -----
package dht_pkg;

   localparam int CFG_W = 11;
   localparam int KEY_W = 31;
   localparam int VAL_W = 32;
   localparam int CNT_W = 5;   // divider step counter, covers KEY_W steps

   typedef enum logic [1:0] {
      MODE_PUT,
      MODE_ERASE,
      MODE_FIND,
      MODE_VACANT
   } mode_type;

   typedef enum logic [1:0] {
      STAT_DONE,
      STAT_NOT_FOUND,
      STAT_FULL
   } status_type;

   typedef enum logic [1:0] {
      MARK_EMPTY,
      MARK_OCCUPIED,
      MARK_DELETED
   } mark_type;

   typedef enum logic {
      REG_TABLE_SIZE,
      REG_STEP_MODULUS
   } reg_index_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_MODQ,
      S_MODN,
      S_MODS,
      S_PROBE,
      S_CHECK,
      S_DONE
   } state_type;

   typedef struct packed {
      mode_type         mode;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value_in;
   } req_type;

   typedef struct packed {
      status_type       status;
      logic [VAL_W-1:0] value_out;
      logic [CFG_W-1:0] free_slots;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [KEY_W-1:0] dividend;
      logic [CFG_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [CFG_W-1:0] rem;
   } div_rsp_type;

endpackage

// ----- hdl/dht_ram.sv -----
module dht_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- hdl/dht_div.sv -----
// Bit-serial restoring remainder: one dividend bit per cycle.
module dht_div (
   input  logic                 clock,
   input  logic                 reset,
   input  dht_pkg::div_req_type div_req,
   output dht_pkg::div_rsp_type div_rsp
);
   import dht_pkg::*;

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [KEY_W-1:0] dvd_ff, dvd_in;
   logic [CFG_W-1:0] dvs_ff, dvs_in;
   logic [CFG_W-1:0] rem_ff, rem_in;
   logic [CFG_W:0]   trial;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      trial   = {rem_ff, dvd_ff[KEY_W-1]};
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvd_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         rem_in  = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[KEY_W-2:0], 1'b0};
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = CFG_W'(trial - {1'b0, dvs_ff});
         end else begin
            rem_in = trial[CFG_W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(KEY_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;

`ifndef SYNTHESIS
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("remainder done without a running division");
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !div_req.start)
      else $error("division restarted while busy");
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff)
      else $error("remainder not below divisor");
`endif

endmodule

// ----- hdl/double_hash_table.sv -----
// Channel  Dir  Handshake           Payload
// req      in   req_valid/req_stall dht_pkg::req_type  {mode, key, value_in}
// rsp      out  rsp_valid/rsp_stall dht_pkg::rsp_type  {status, value_out, free_slots}
// csr      in   csr_we              csr_index, csr_wdata (table_size, step_modulus)
//
// One transaction at a time. A put/erase/find first runs the modulo steps
// (key mod q, key mod n, step mod n on the shared bit-serial divider), then
// a slot RAM read followed by a check for each probe, then a finish step that
// delivers the result. A vacant query skips the modulo and probe steps.
// After reset, and after every table_size write, a clearing pass writes all
// MAX_SLOTS (capped at 2047) entries, one per cycle; req is stalled meanwhile.
// The result sits in an output register; rsp_stall only holds the sequencer
// once it has a new result to deliver.
module double_hash_table #(
   parameter int MAX_SLOTS  = 1024,
   parameter int VALUE_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  dht_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output dht_pkg::rsp_type              rsp_data,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [dht_pkg::CFG_W-1:0]     csr_wdata
);
   import dht_pkg::*;

   // table_size is 11 bits, so no more than 2047 slots are ever reachable
   localparam int MAX_EFF = (MAX_SLOTS > 2047) ? 2047 : MAX_SLOTS;
   localparam int AW      = $clog2(MAX_EFF);
   localparam int WORD_W  = 2 + KEY_W + VALUE_BITS;

   state_type        state_ff, state_in;
   logic [CFG_W-1:0] table_size_ff, table_size_in;
   logic [CFG_W-1:0] step_mod_ff, step_mod_in;
   logic [CFG_W-1:0] occ_ff, occ_in;
   req_type          req_ff, req_in;
   logic [CFG_W-1:0] step_ff, step_in;    // q - key mod q
   logic [CFG_W-1:0] stepn_ff, stepn_in;  // step mod n
   logic [CFG_W-1:0] idx_ff, idx_in;
   logic [CFG_W-1:0] probe_ff, probe_in;
   logic [AW-1:0]    clr_ff, clr_in;
   status_type       stat_ff, stat_in;
   logic [VAL_W-1:0] vout_ff, vout_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   logic [CFG_W-1:0] n_eff, q_eff;
   div_req_type      div_req;
   div_rsp_type      div_rsp;

   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [WORD_W-1:0] ram_wdata;
   logic [WORD_W-1:0] ram_rdata;

   mark_type          rd_mark;
   logic [KEY_W-1:0]  rd_key;
   logic [VALUE_BITS-1:0] rd_val;
   logic [63:0]       rd_val64, in_val64;
   logic [CFG_W:0]    idx_sum;
   logic [CFG_W-1:0]  idx_adv;
   logic              last_probe;

   assign n_eff = (table_size_ff == '0) ? CFG_W'(1) :
                  (table_size_ff > CFG_W'(MAX_EFF)) ? CFG_W'(MAX_EFF) : table_size_ff;
   assign q_eff = (step_mod_ff == '0) ? CFG_W'(1) : step_mod_ff;

   // slot word: {mark, key, value}
   assign rd_mark  = mark_type'(ram_rdata[WORD_W-1 -: 2]);
   assign rd_key   = ram_rdata[VALUE_BITS +: KEY_W];
   assign rd_val   = ram_rdata[VALUE_BITS-1:0];
   assign rd_val64 = 64'(rd_val);
   assign in_val64 = 64'(req_ff.value_in);

   assign idx_sum    = {1'b0, idx_ff} + {1'b0, stepn_ff};
   assign idx_adv    = (idx_sum >= {1'b0, n_eff}) ? CFG_W'(idx_sum - {1'b0, n_eff})
                                                  : idx_sum[CFG_W-1:0];
   assign last_probe = (probe_ff == CFG_W'(n_eff - 1'b1));

   dht_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   dht_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_EFF)
   ) u_slots (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (idx_ff[AW-1:0]),
      .rdata (ram_rdata)
   );

   always_comb begin
      state_in      = state_ff;
      table_size_in = table_size_ff;
      step_mod_in   = step_mod_ff;
      occ_in        = occ_ff;
      req_in        = req_ff;
      step_in       = step_ff;
      stepn_in      = stepn_ff;
      idx_in        = idx_ff;
      probe_in      = probe_ff;
      clr_in        = clr_ff;
      stat_in       = stat_ff;
      vout_in       = vout_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      req_stall     = 1'b1;
      div_req       = '0;
      ram_we        = 1'b0;
      ram_waddr     = idx_ff[AW-1:0];
      ram_wdata     = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = {MARK_EMPTY, {(WORD_W-2){1'b0}}};
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == AW'(MAX_EFF - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               req_in  = req_data;
               stat_in = STAT_DONE;
               vout_in = '0;
               if (req_data.mode == MODE_VACANT) begin
                  state_in = S_DONE;
               end else begin
                  div_req.start    = 1'b1;
                  div_req.dividend = req_data.key;
                  div_req.divisor  = q_eff;
                  state_in         = S_MODQ;
               end
            end
         end
         S_MODQ: begin
            if (div_rsp.done) begin
               step_in          = q_eff - div_rsp.rem;
               div_req.start    = 1'b1;
               div_req.dividend = req_ff.key;
               div_req.divisor  = n_eff;
               state_in         = S_MODN;
            end
         end
         S_MODN: begin
            if (div_rsp.done) begin
               idx_in           = div_rsp.rem;
               div_req.start    = 1'b1;
               div_req.dividend = KEY_W'(step_ff);
               div_req.divisor  = n_eff;
               state_in         = S_MODS;
            end
         end
         S_MODS: begin
            if (div_rsp.done) begin
               stepn_in = div_rsp.rem;
               probe_in = '0;
               state_in = S_PROBE;
            end
         end
         S_PROBE: begin
            state_in = S_CHECK;   // slot read in flight
         end
         S_CHECK: begin
            state_in = S_DONE;
            if (req_ff.mode == MODE_PUT) begin
               if (rd_mark != MARK_OCCUPIED) begin
                  ram_we    = 1'b1;
                  ram_wdata = {MARK_OCCUPIED, req_ff.key, in_val64[VALUE_BITS-1:0]};
                  if (occ_ff < n_eff) begin
                     occ_in = occ_ff + 1'b1;
                  end
               end else if (last_probe) begin
                  stat_in = STAT_FULL;
               end else begin
                  state_in = S_PROBE;
               end
            end else begin
               if (rd_mark == MARK_EMPTY) begin
                  stat_in = STAT_NOT_FOUND;
               end else if (rd_mark == MARK_OCCUPIED && rd_key == req_ff.key) begin
                  vout_in = rd_val64[VAL_W-1:0];
                  if (req_ff.mode == MODE_ERASE) begin
                     ram_we    = 1'b1;
                     ram_wdata = {MARK_DELETED, rd_key, rd_val};
                     if (occ_ff != '0) begin
                        occ_in = occ_ff - 1'b1;
                     end
                  end
               end else if (last_probe) begin
                  stat_in = STAT_NOT_FOUND;
               end else begin
                  state_in = S_PROBE;
               end
            end
            if (state_in == S_PROBE) begin
               idx_in   = idx_adv;
               probe_in = probe_ff + 1'b1;
            end
         end
         S_DONE: begin
            // output register free, or being emptied this cycle
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in      = 1'b1;
               rsp_in.status     = stat_ff;
               rsp_in.value_out  = vout_ff;
               rsp_in.free_slots = n_eff - occ_ff;
               state_in          = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
            clr_in   = '0;
         end
      endcase

      // configuration: the user must write it only while idle; not enforced here
      if (csr_we) begin
         if (reg_index_type'(csr_index) == REG_TABLE_SIZE) begin
            table_size_in = csr_wdata;
            occ_in        = '0;
            clr_in        = '0;
            state_in      = S_CLEAR;
         end else begin
            step_mod_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         table_size_ff <= CFG_W'(1024);
         step_mod_ff   <= CFG_W'(7);
         occ_ff        <= '0;
         clr_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         table_size_ff <= table_size_in;
         step_mod_ff   <= step_mod_in;
         occ_ff        <= occ_in;
         clr_ff        <= clr_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      req_ff   <= req_in;
      step_ff  <= step_in;
      stepn_ff <= stepn_in;
      idx_ff   <= idx_in;
      probe_ff <= probe_in;
      stat_ff  <= stat_in;
      vout_ff  <= vout_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTHESIS
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= n_eff)
      else $error("occupied count above table size");
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PROBE || state_ff == S_CHECK) |-> idx_ff < n_eff)
      else $error("probe index outside table");
   a_write_ctx: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (state_ff == S_CLEAR || state_ff == S_CHECK))
      else $error("slot write outside clear or check");
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised outside completion");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

// Self-checking bench for double_hash_table.
// A shadow table in the bench predicts each transaction's response at the
// moment the request is accepted. A monitor compares every delivered response
// field by field against the oldest prediction.
module testbench;
   import dht_pkg::*;

   localparam int SLOTS    = 1024;
   localparam int WD_LIMIT = 60000;   // idle cycles allowed before giving up

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [CFG_W-1:0] csr_wdata = '0;

   double_hash_table uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // shadow copy of the table and its registers
   mark_type        shadow_mark [SLOTS];
   logic [KEY_W-1:0] shadow_key [SLOTS];
   logic [VAL_W-1:0] shadow_val [SLOTS];
   int unsigned     shadow_occ;
   logic [CFG_W-1:0] shadow_size;
   logic [CFG_W-1:0] shadow_q;

   rsp_type pending_answers[$];
   int      errors = 0;
   int      checked = 0;
   int      mode_count[4];
   int      full_count = 0;
   int      miss_count = 0;
   int      send_idle = 0;   // percent of cycles the sender holds back
   int      recv_idle = 0;   // percent of cycles the receiver stalls
   bit      hold_rsp = 1'b0; // long receiver hold-off
   int      quiet_cycles = 0;

   function automatic void clear_shadow();
      for (int i = 0; i < SLOTS; i++) shadow_mark[i] = MARK_EMPTY;
      shadow_occ = 0;
   endfunction

   function automatic int unsigned used_slots();
      if (shadow_size == 0) return 1;
      if (shadow_size > SLOTS) return SLOTS;
      return shadow_size;
   endfunction

   // Applies one transaction to the shadow table, returns its response.
   function automatic rsp_type table_op(req_type r);
      rsp_type     a;
      int unsigned n, q, stride, idx, k;
      bit          done;
      n = used_slots();
      q = (shadow_q == 0) ? 1 : shadow_q;
      k = r.key;
      stride = q - (k % q);
      idx = k % n;
      done = 1'b0;
      a.status = STAT_DONE;
      a.value_out = '0;
      case (r.mode)
         MODE_PUT: begin
            for (int p = 0; p < n && !done; p++) begin
               if (shadow_mark[idx] != MARK_OCCUPIED) begin
                  shadow_mark[idx] = MARK_OCCUPIED;
                  shadow_key[idx] = r.key;
                  shadow_val[idx] = r.value_in;
                  if (shadow_occ < n) shadow_occ++;
                  done = 1'b1;
               end else idx = (idx + stride) % n;
            end
            if (!done) a.status = STAT_FULL;
         end
         MODE_ERASE, MODE_FIND: begin
            // empty slot ends the walk, deleted ones are skipped
            for (int p = 0; p < n && !done; p++) begin
               if (shadow_mark[idx] == MARK_EMPTY) break;
               if (shadow_mark[idx] == MARK_OCCUPIED && shadow_key[idx] == r.key)
                  done = 1'b1;
               else idx = (idx + stride) % n;
            end
            if (!done) a.status = STAT_NOT_FOUND;
            else begin
               a.value_out = shadow_val[idx];
               if (r.mode == MODE_ERASE) begin
                  shadow_mark[idx] = MARK_DELETED;
                  if (shadow_occ > 0) shadow_occ--;
               end
            end
         end
         default: ;
      endcase
      a.free_slots = CFG_W'(n - ((shadow_occ <= n) ? shadow_occ : n));
      return a;
   endfunction

   task automatic report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch #%0d %s: got %0h expected %0h (t=%0t)", checked, what, got, want,
               $realtime);
      errors++;
   endtask

   // one request transaction; prediction happens at the accepting edge
   task automatic send_req(mode_type m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
      req_type r;
      r.mode = m;
      r.key = k;
      r.value_in = v;
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_answers.push_back(table_op(r));
      mode_count[m]++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // register write, only with the block idle
   task automatic write_reg(reg_index_type idx, logic [CFG_W-1:0] v);
      drain();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_TABLE_SIZE) begin
         shadow_size = v;
         clear_shadow();
      end else shadow_q = v;
   endtask

   // receiver: random stall, or held high during a hold-off
   always @(posedge clock)
      rsp_stall <= hold_rsp ? 1'b1 : ($urandom_range(99) < recv_idle);

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_type want;
         if (pending_answers.size() == 0) begin
            report("unexpected response", rsp_data, 0);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_data.status != want.status)
               report("status", rsp_data.status, want.status);
            if (rsp_data.value_out != want.value_out)
               report("value_out", rsp_data.value_out, want.value_out);
            if (rsp_data.free_slots != want.free_slots)
               report("free_slots", rsp_data.free_slots, want.free_slots);
            if (want.status == STAT_FULL) full_count++;
            if (want.status == STAT_NOT_FOUND) miss_count++;
         end
         checked++;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_we || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WD_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", WD_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // put/find/erase/vacant at the default settings, key and value extremes
   task automatic test_basic_ops();
      send_req(MODE_VACANT, '0, '0);
      send_req(MODE_PUT, 31'd0, 32'h0000_0000);
      send_req(MODE_PUT, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_req(MODE_PUT, 31'd1024, 32'hA5A5_5A5A);   // collides with key 0
      send_req(MODE_FIND, 31'd1024, '1);
      send_req(MODE_FIND, 31'h7FFF_FFFF, '0);
      send_req(MODE_ERASE, 31'd0, '0);
      send_req(MODE_FIND, 31'd1024, '0);             // walks over a deleted slot
      send_req(MODE_FIND, 31'd0, '0);                // not found
      send_req(MODE_ERASE, 31'd0, '0);
      send_req(MODE_PUT, 31'd2048, 32'h1234_5678);   // reuses the deleted slot
      send_req(MODE_PUT, 31'd2048, 32'h8765_4321);   // duplicate key
      send_req(MODE_ERASE, 31'd2048, '0);
      send_req(MODE_FIND, 31'd2048, '0);
      send_req(MODE_VACANT, 31'h7FFF_FFFF, '1);
   endtask

   // table size and step modulus extremes, full table, keep on q change
   task automatic test_reg_edges();
      write_reg(REG_TABLE_SIZE, 11'd1);
      send_req(MODE_PUT, 31'd5, 32'd11);
      send_req(MODE_PUT, 31'd6, 32'd22);             // table full
      send_req(MODE_FIND, 31'd5, '0);
      write_reg(REG_TABLE_SIZE, 11'd0);              // acts as one slot
      send_req(MODE_PUT, 31'd9, 32'd3);
      send_req(MODE_PUT, 31'd9, 32'd4);
      write_reg(REG_STEP_MODULUS, 11'd0);            // acts as one
      write_reg(REG_TABLE_SIZE, 11'd4);
      for (int i = 0; i < 5; i++) send_req(MODE_PUT, 31'(i * 4), 32'(i));
      send_req(MODE_FIND, 31'd12, '0);
      write_reg(REG_STEP_MODULUS, 11'd3);            // table kept
      send_req(MODE_FIND, 31'd12, '0);
      send_req(MODE_VACANT, '0, '0);
      write_reg(REG_STEP_MODULUS, 11'd2047);
      write_reg(REG_TABLE_SIZE, 11'd2047);           // capped at the slot count
      send_req(MODE_PUT, 31'd3000, 32'd1);
      send_req(MODE_FIND, 31'd3000, '0);
      write_reg(REG_STEP_MODULUS, 11'd1024);
      send_req(MODE_PUT, 31'd3000, 32'd2);
      send_req(MODE_VACANT, '0, '0);
   endtask

   task automatic random_op(int unsigned n);
      int unsigned pick, m;
      logic [KEY_W-1:0] k;
      pick = $urandom_range(99);
      m = (pick < 38) ? MODE_PUT : (pick < 60) ? MODE_ERASE : (pick < 90) ? MODE_FIND
                                                                        : MODE_VACANT;
      if ($urandom_range(9) < 8) k = KEY_W'($urandom_range(2 * n + 5));
      else if ($urandom_range(1)) k = KEY_W'(31'h7FFF_FFFF - $urandom_range(4 * n));
      else k = KEY_W'($urandom);
      send_req(mode_type'(m), k, $urandom);
   endtask

   // segments with their own settings; mostly small tables so walks stay short
   task automatic test_random(int items);
      int unsigned n, q;
      int sent;
      sent = 0;
      while (sent < items) begin
         case ($urandom_range(9))
            0: n = 1024;
            1: n = $urandom_range(30, 100);
            default: n = $urandom_range(1, 20);
         endcase
         q = ($urandom_range(7) == 0) ? $urandom_range(2047) : $urandom_range(1, n + 3);
         write_reg(REG_TABLE_SIZE, CFG_W'(n));
         write_reg(REG_STEP_MODULUS, CFG_W'(q));
         for (int i = 0; i < 60; i++) random_op(n);
         sent += 60;
      end
   endtask

   // receiver holds off while requests keep coming, then a pause until empty
   task automatic test_backpressure();
      write_reg(REG_TABLE_SIZE, 11'd8);
      write_reg(REG_STEP_MODULUS, 11'd5);
      fork
         begin
            hold_rsp = 1'b1;
            repeat (3000) @(posedge clock);
            hold_rsp = 1'b0;
         end
      join_none
      for (int i = 0; i < 12; i++) random_op(8);
      drain();
      for (int i = 0; i < 10; i++) random_op(8);
   endtask

   initial begin
      clear_shadow();
      shadow_size = 11'd1024;
      shadow_q = 11'd7;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_basic_ops();
      test_reg_edges();
      send_idle = 33; recv_idle = 52;
      test_random(600);
      send_idle = 52; recv_idle = 33;
      test_random(600);
      send_idle = 0; recv_idle = 0;
      test_random(600);
      test_backpressure();

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d puts, %0d erases, %0d finds, %0d vacant queries",
               mode_count[MODE_PUT], mode_count[MODE_ERASE], mode_count[MODE_FIND],
               mode_count[MODE_VACANT]);
      $display("%0d responses checked, %0d table-full, %0d not-found, %0d mismatches",
               checked, full_count, miss_count, errors);
      if (errors == 0 && pending_answers.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
